// ----- hw/rtl/grev_pkg.sv -----
// Shared widths, defaults, controller states and command/status types for the group reverser.
package grev_pkg;

    localparam int VALUE_W       = 32;
    localparam int GSIZE_W       = 7;
    localparam int MAX_GROUP_DEF = 64;
    localparam int GSIZE_RESET   = 1;
    localparam int MIN_GROUP     = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic wr;
        logic rd;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic last;
    } t_status;

endpackage

// ----- hw/rtl/grev_if.sv -----
// Channel interfaces: configuration, input request and result request.
interface grev_cfg_if import grev_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [GSIZE_W-1:0] group_size;

    modport source (output valid, output group_size, input ready);
    modport sink   (input valid, input group_size, output ready);
endinterface

interface grev_in_if import grev_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      seq_end;

    modport source (output valid, output value, output seq_end, input ready);
    modport sink   (input valid, input value, input seq_end, output ready);
endinterface

interface grev_out_if import grev_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value_res;
    logic                      run_last;
    logic                      out_end;

    modport source (output valid, output value_res, output run_last, output out_end,
                    input ready);
    modport sink   (input valid, input value_res, input run_last, input out_end,
                    output ready);
endinterface

// ----- hw/rtl/grev_ctrl.sv -----
// Controller state machine: sequences buffer writes, reads and result requests.
module grev_ctrl import grev_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.emit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.wr   = i_in_valid;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.done = i_status.last;
                    o_cmd.rd   = !i_status.last;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/grev_dpath.sv -----
// Datapath: group size register, fill count, group buffer memory and result register.
module grev_dpath import grev_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic                      i_cfg_wr,
    input  logic [GSIZE_W-1:0]        i_group_size,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_seq_end,
    output t_status                   o_status,
    output logic signed [VALUE_W-1:0] o_value_res,
    output logic                      o_run_last,
    output logic                      o_out_end
);

    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int KW = (CW > GSIZE_W) ? CW : GSIZE_W;

    logic [VALUE_W-1:0] r_mem [MAX_GROUP];

    logic [GSIZE_W-1:0] r_gsize;
    logic [CW-1:0]      r_fill;
    logic [IW-1:0]      r_ptr;
    logic               r_rev;
    logic               r_seq_end;
    logic [VALUE_W-1:0] r_data;
    logic               r_last;
    logic               r_end;

    logic [KW-1:0]      w_k;
    logic [CW-1:0]      w_new_fill;
    logic               w_full;
    logic               w_rd_last;

    always_comb begin
        if (KW'(r_gsize) < KW'(MIN_GROUP)) begin
            w_k = KW'(1);
        end else if (KW'(r_gsize) > KW'(MAX_GROUP)) begin
            w_k = KW'(MAX_GROUP);
        end else begin
            w_k = KW'(r_gsize);
        end
    end

    assign w_new_fill = r_fill + CW'(1);
    assign w_full     = KW'(w_new_fill) >= w_k;
    assign w_rd_last  = r_rev ? (r_ptr == '0) : (CW'(r_ptr) == r_fill - CW'(1));

    assign o_status.emit = w_full || i_seq_end;
    assign o_status.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsize <= GSIZE_W'(GSIZE_RESET);
            r_fill  <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_gsize <= i_group_size;
            end
            if (i_cmd.wr) begin
                r_fill <= w_new_fill;
            end else if (i_cmd.done) begin
                r_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_ptr     <= w_full ? r_fill[IW-1:0] : '0;
            r_rev     <= w_full;
            r_seq_end <= i_seq_end;
        end else if (i_cmd.rd) begin
            r_ptr  <= r_rev ? r_ptr - IW'(1) : r_ptr + IW'(1);
            r_last <= w_rd_last;
            r_end  <= w_rd_last && r_seq_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_fill[IW-1:0]] <= i_value;
        end
        if (i_cmd.rd) begin
            r_data <= r_mem[r_ptr];
        end
    end

    assign o_value_res = r_data;
    assign o_run_last  = r_last;
    assign o_out_end   = r_end;

endmodule

// ----- hw/rtl/group_reverse_stream.sv -----
// Top level of the group reverser: controller, datapath and channel ports.
// A request that completes a group leads to ST_READ, and then ST_OUT shows its first result.
// A request that emits nothing leaves the controller in ST_IDLE; after a completing request,
// no new request is taken until the last result of the group has left ST_OUT.
// Results of a group leave one per cycle while the sink is ready.
// Reset (synchronous, active low) empties the buffer count and sets the group size to 1.
module group_reverse_stream import grev_pkg::*; #(
    parameter int MAX_GROUP = MAX_GROUP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    grev_cfg_if.sink          i_cfg,
    grev_in_if.sink           i_in,
    grev_out_if.source        o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    assign i_cfg.ready = 1'b1;

    grev_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    grev_dpath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_wr     (i_cfg.valid && i_cfg.ready),
        .i_group_size (i_cfg.group_size),
        .i_value      (i_in.value),
        .i_seq_end    (i_in.seq_end),
        .o_status     (w_status),
        .o_value_res  (o_out.value_res),
        .o_run_last   (o_out.run_last),
        .o_out_end    (o_out.out_end)
    );

    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.valid && i_in.ready && o_out.valid))
        else $error("request accepted while a result is pending");

    a_wr_rd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr && w_cmd.rd))
        else $error("buffer write and read in one cycle");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_end) |-> o_out.run_last)
        else $error("sequence end on a result that is not the last of its request");

    a_done_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.done |=> (i_in.ready && !o_out.valid))
        else $error("input not freed after final result");

endmodule
